// ===== hdl/nsr_pkg.sv =====
// Shared types and constants for the Newton square root block.
`default_nettype none

package nsr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned TOL_W  = 25;
  localparam int unsigned CNT_W  = 7;

  localparam logic [DATA_W-1:0] GUESS_RESET = 32'h0200_0000;
  localparam logic [TOL_W-1:0]  TOL_RESET   = 25'd1678;

  typedef enum logic {
    CFG_IDX_GUESS = 1'b0,
    CFG_IDX_TOL   = 1'b1
  } nsr_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_DONE
  } nsr_state_e;

endpackage

`default_nettype wire

// ===== hdl/nsr_divider.sv =====
// Restoring fixed-point divider: floor((num << FRAC_BITS) / den), saturated to 32 bits.
`default_nettype none

module nsr_divider #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [nsr_pkg::DATA_W-1:0]  num_i,
  input  wire logic [nsr_pkg::DATA_W-1:0]  den_i,
  output logic                             done_o,
  output logic [nsr_pkg::DATA_W-1:0]       quotient_o
);

  localparam int unsigned DW   = nsr_pkg::DATA_W;
  localparam int unsigned NW   = DW + FRAC_BITS;
  localparam int unsigned XW   = 2 * DW;
  localparam int unsigned CW   = $clog2(DW + 1);

  logic [NW-1:0] num_ext;
  logic          ovf;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   trial_sub;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] lo_q, lo_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] quo_q, quo_d;

  // Quotient overflows 32 bits exactly when num << FRAC_BITS >= den << 32.
  assign num_ext = {num_i, {FRAC_BITS{1'b0}}};
  assign ovf     = {{(XW-NW){1'b0}}, num_ext} >= {den_i, {DW{1'b0}}};

  assign trial     = {rem_q, lo_q[DW-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      if (ovf) begin
        quo_d  = {DW{1'b1}};
        done_d = 1'b1;
      end else begin
        // No overflow implies the upper numerator bits are already below den.
        rem_d  = {{(DW-FRAC_BITS){1'b0}}, num_ext[NW-1:DW]};
        lo_d   = num_ext[DW-1:0];
        den_d  = den_i;
        cnt_d  = CW'(DW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      lo_d  = {lo_q[DW-2:0], 1'b0};
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hdl/newton_square_root.sv =====
// Newton-Raphson square root of unsigned fixed-point radicands, with iteration counters.
//
// Each input transaction carries one unsigned radicand with FRAC_BITS fraction bits
// (Q8.24 by default). Starting from the initial_guess register, the block repeats
// x' = (x + (s << FRAC_BITS) / x) / 2 until |x' - x| <= tolerance or MAX_ITERATIONS
// steps have run, then returns one result transaction: the root, the step count, a
// converged flag, a saturating running total of steps and the largest per-item step
// count since reset. A zero radicand returns root 0, zero steps and converged set,
// and leaves both counters alone. All arithmetic runs through one shared restoring
// divider that resolves one quotient bit per cycle; a quotient that would exceed 32
// bits (including division by zero) saturates to all ones without the bit-serial run.
// Each Newton step runs the quotient bits, then averages the estimate and tests the
// step size; the next division starts while the step size is tested. Only one item
// is in flight: in_ready_o is high while the sequencer is idle, which includes the
// time a finished result sits in the output register waiting for out_ready_i.
// Configuration writes through cfg_we_i take effect at once and must only be issued
// while no transaction is in flight.
`default_nettype none

module newton_square_root #(
  parameter int unsigned MAX_ITERATIONS = 64,
  parameter int unsigned FRAC_BITS      = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [nsr_pkg::DATA_W-1:0]  cfg_data_i,
  // Input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [nsr_pkg::DATA_W-1:0]  radicand_i,
  // Output channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [nsr_pkg::DATA_W-1:0]       root_o,
  output logic [nsr_pkg::CNT_W-1:0]        iterations_used_o,
  output logic                             converged_o,
  output logic [nsr_pkg::DATA_W-1:0]       total_iterations_o,
  output logic [nsr_pkg::CNT_W-1:0]        most_iterations_o
);

  localparam int unsigned DW = nsr_pkg::DATA_W;
  localparam int unsigned TW = nsr_pkg::TOL_W;
  localparam int unsigned CW = nsr_pkg::CNT_W;
  localparam int unsigned IW = $clog2(MAX_ITERATIONS + 1);

  nsr_pkg::nsr_state_e state_q, state_d;

  // Configuration registers
  logic [DW-1:0] guess_q;
  logic [TW-1:0] tol_q;

  // Working registers for the item in flight
  logic [DW-1:0] rad_q, rad_d;
  logic [DW-1:0] x_q, x_d;
  logic [DW-1:0] xn_q, xn_d;
  logic [IW-1:0] steps_q, steps_d;
  logic          conv_q, conv_d;

  // Running counters
  logic [DW-1:0] total_q, total_d;
  logic [CW-1:0] peak_q, peak_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] root_q, root_d;
  logic [CW-1:0] iter_out_q, iter_out_d;
  logic          conv_out_q, conv_out_d;
  logic [DW-1:0] total_out_q, total_out_d;
  logic [CW-1:0] peak_out_q, peak_out_d;

  // Divider interface
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quo;

  // Datapath helpers
  logic [DW:0]   avg_sum;
  logic [DW-1:0] step_diff;
  logic          tol_met;
  logic          at_cap;
  logic [DW:0]   total_sum;
  logic          in_accept;

  // The divider captures its operands on the start edge, so feed it the values
  // that the radicand and estimate registers take at that same edge.
  nsr_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (rad_d),
    .den_i      (x_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o = (state_q == nsr_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Average of estimate and quotient in 33 bits, so it always fits back in 32.
  assign avg_sum   = {1'b0, x_q} + {1'b0, div_quo};
  assign step_diff = (xn_q >= x_q) ? (xn_q - x_q) : (x_q - xn_q);
  assign tol_met   = step_diff <= {{(DW-TW){1'b0}}, tol_q};
  assign at_cap    = (steps_q == IW'(MAX_ITERATIONS));
  assign total_sum = {1'b0, total_q} + {{(DW+1-IW){1'b0}}, steps_q};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guess_q <= nsr_pkg::GUESS_RESET;
      tol_q   <= nsr_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (nsr_pkg::nsr_cfg_idx_e'(cfg_index_i))
        nsr_pkg::CFG_IDX_GUESS: guess_q <= cfg_data_i;
        nsr_pkg::CFG_IDX_TOL:   tol_q   <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state, datapath updates and divider control
  always_comb begin
    state_d     = state_q;
    rad_d       = rad_q;
    x_d         = x_q;
    xn_d        = xn_q;
    steps_d     = steps_q;
    conv_d      = conv_q;
    total_d     = total_q;
    peak_d      = peak_q;
    out_valid_d = out_valid_q;
    root_d      = root_q;
    iter_out_d  = iter_out_q;
    conv_out_d  = conv_out_q;
    total_out_d = total_out_q;
    peak_out_d  = peak_out_q;
    div_start   = 1'b0;

    // Drop the result once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      nsr_pkg::ST_IDLE: begin
        if (in_accept) begin
          rad_d   = radicand_i;
          x_d     = guess_q;
          xn_d    = '0;
          steps_d = '0;
          if (radicand_i == '0) begin
            // Exact answer, no steps, counters untouched.
            conv_d  = 1'b1;
            state_d = nsr_pkg::ST_DONE;
          end else begin
            conv_d  = 1'b0;
            state_d = nsr_pkg::ST_DIV;
          end
        end
      end

      nsr_pkg::ST_DIV: begin
        // Kick the divider on entry; hold until it reports a quotient.
        if (div_done) begin
          xn_d    = avg_sum[DW:1];
          steps_d = steps_q + IW'(1);
          state_d = nsr_pkg::ST_STEP;
        end
      end

      nsr_pkg::ST_STEP: begin
        if (tol_met || at_cap) begin
          conv_d  = tol_met;
          // Saturate the running total on carry out.
          total_d = total_sum[DW] ? {DW{1'b1}} : total_sum[DW-1:0];
          if (CW'(steps_q) > peak_q) begin
            peak_d = CW'(steps_q);
          end
          state_d = nsr_pkg::ST_DONE;
        end else begin
          x_d     = xn_q;
          state_d = nsr_pkg::ST_DIV;
        end
      end

      nsr_pkg::ST_DONE: begin
        // Load the output register as soon as it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          root_d      = xn_q;
          iter_out_d  = CW'(steps_q);
          conv_out_d  = conv_q;
          total_out_d = total_q;
          peak_out_d  = peak_q;
          state_d     = nsr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = nsr_pkg::ST_IDLE;
      end
    endcase

    // Start a division on every entry into the divide state.
    if ((state_d == nsr_pkg::ST_DIV) && (state_q != nsr_pkg::ST_DIV)) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nsr_pkg::ST_IDLE;
      total_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q       <= rad_d;
    x_q         <= x_d;
    xn_q        <= xn_d;
    steps_q     <= steps_d;
    conv_q      <= conv_d;
    root_q      <= root_d;
    iter_out_q  <= iter_out_d;
    conv_out_q  <= conv_out_d;
    total_out_q <= total_out_d;
    peak_out_q  <= peak_out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign root_o             = root_q;
  assign iterations_used_o  = iter_out_q;
  assign converged_o        = conv_out_q;
  assign total_iterations_o = total_out_q;
  assign most_iterations_o  = peak_out_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_newton_square_root.sv =====
// Self-checking testbench for the Newton-Raphson fixed-point square root block.
`default_nettype none

module tb_newton_square_root;

  localparam int unsigned MAX_ITER     = 64;
  localparam int unsigned FRAC         = 24;
  localparam int unsigned DATA_W       = nsr_pkg::DATA_W;
  localparam int unsigned TOL_W        = nsr_pkg::TOL_W;
  localparam int unsigned CNT_W        = nsr_pkg::CNT_W;
  // Sender gap and receiver stall ceilings, in cycles
  localparam int unsigned MAX_GAP      = 60;
  localparam int unsigned MAX_STALL    = 40;
  // Settle time after the last result before reconfiguring or finishing
  localparam int unsigned SETTLE       = 16;
  // Slowest legal item: handoff plus a capped run of Newton steps, plus the
  // longest gap and stall; the limit takes that for a generous item budget, 4x over.
  localparam int unsigned ITEM_BUDGET  = 1600;
  localparam int unsigned ITEM_WORST   = 3 + 35 * MAX_ITER + MAX_GAP + MAX_STALL + SETTLE;
  localparam int unsigned CYCLE_LIMIT  = 4 * ITEM_BUDGET * ITEM_WORST;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic [CNT_W-1:0]  iters;
    logic              conv;
    logic [DATA_W-1:0] total;
    logic [CNT_W-1:0]  peak;
  } sqrt_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_index_i = nsr_pkg::CFG_IDX_GUESS;
  logic [DATA_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [DATA_W-1:0] radicand_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DATA_W-1:0] root_o;
  logic [CNT_W-1:0]  iterations_used_o;
  logic              converged_o;
  logic [DATA_W-1:0] total_iterations_o;
  logic [CNT_W-1:0]  most_iterations_o;

  newton_square_root #(
    .MAX_ITERATIONS(MAX_ITER),
    .FRAC_BITS     (FRAC)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .radicand_i        (radicand_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .root_o            (root_o),
    .iterations_used_o (iterations_used_o),
    .converged_o       (converged_o),
    .total_iterations_o(total_iterations_o),
    .most_iterations_o (most_iterations_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copies of the configuration and the running counters
  logic [DATA_W-1:0] cur_guess = nsr_pkg::GUESS_RESET;
  logic [TOL_W-1:0]  cur_tol   = nsr_pkg::TOL_RESET;
  logic [DATA_W-1:0] iter_total = '0;
  logic [CNT_W-1:0]  iter_peak  = '0;

  logic [DATA_W-1:0] pending_radicands [$];
  sqrt_result_t      sqrt_expected [$];

  int unsigned items_sent     = 0;
  int unsigned zero_sent      = 0;
  int unsigned results_seen   = 0;
  int unsigned capped_seen    = 0;
  int unsigned err_count      = 0;
  int unsigned cfg_writes     = 0;
  int unsigned cycle_count    = 0;

  // Corners: zero, smallest and largest codes, exact powers, alternating bit
  // patterns, and a radicand whose fixed-point iteration flips between two
  // neighbors forever, which hits the iteration cap once tolerance is zero.
  logic [DATA_W-1:0] corner_radicands [16] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0100_0000,
    32'h0400_0000, 32'h0200_0000, 32'h0040_0001, 32'h8000_0000,
    32'h00FF_FFFF, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h0000_0000, 32'h1000_0000, 32'h0000_0100, 32'hFFFF_FFFE
  };

  // Work out one result from the shadow state and advance the counters.
  function automatic sqrt_result_t predict_sqrt(input logic [DATA_W-1:0] s);
    sqrt_result_t      r;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] xn;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] steps;
    logic [63:0]       quot;
    logic [DATA_W:0]   sum;
    logic              met;
    x     = cur_guess;
    xn    = '0;
    steps = '0;
    met   = 1'b0;
    if (s == '0) begin
      // Zero radicand: exact answer, counters untouched
      met = 1'b1;
    end else begin
      while (steps < MAX_ITER && !met) begin
        // Zero divisor and over-range quotients saturate to all ones
        if (x == '0) begin
          q = '1;
        end else begin
          quot = ({32'b0, s} << FRAC) / {32'b0, x};
          q    = (quot > 64'h0000_0000_FFFF_FFFF) ? '1 : quot[DATA_W-1:0];
        end
        sum   = {1'b0, x} + {1'b0, q};
        xn    = sum[DATA_W:1];
        steps = steps + 1;
        diff  = (xn >= x) ? (xn - x) : (x - xn);
        if (diff <= {{(DATA_W-TOL_W){1'b0}}, cur_tol}) begin
          met = 1'b1;
        end else begin
          x = xn;
        end
      end
      if (32'hFFFF_FFFF - iter_total < steps) begin
        iter_total = '1;
      end else begin
        iter_total = iter_total + steps;
      end
      if (steps > {{(DATA_W-CNT_W){1'b0}}, iter_peak}) begin
        iter_peak = steps[CNT_W-1:0];
      end
    end
    r.root  = xn;
    r.iters = steps[CNT_W-1:0];
    r.conv  = met;
    r.total = iter_total;
    r.peak  = iter_peak;
    return r;
  endfunction

  // Mix of value classes so both tiny and huge radicands show up often.
  function automatic logic [DATA_W-1:0] pick_radicand();
    logic [15:0] m;
    case ($urandom_range(0, 19))
      0: begin
        return '0;
      end
      1, 2, 3, 4, 5, 6: begin
        return $urandom();
      end
      7, 8: begin
        return $urandom_range(1, 255);
      end
      9, 10, 11: begin
        return $urandom_range(1, 32'h00FF_FFFF);
      end
      12, 13: begin
        // Perfect squares: the root lands exactly on m << 12
        m = $urandom_range(1, 16'hFFFF);
        return {16'b0, m} * {16'b0, m};
      end
      14: begin
        return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
      end
      15: begin
        return 32'h1 << $urandom_range(0, 31);
      end
      default: begin
        return $urandom_range(32'h0100_0000, 32'h1000_0000);
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Record each accepted transaction at the rising edge; the driver acts on it at
  // the following falling edge while the payload is still on the port.
  logic in_accepted;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid_i && in_ready_o;
    end
  end

  // Driver: predict on acceptance, then present the next radicand in bursts
  // separated by random gaps (sometimes none at all).
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  always @(negedge clk_i) begin
    logic drive_valid;
    drive_valid = in_valid_i;
    if (in_accepted) begin
      sqrt_expected.push_back(predict_sqrt(radicand_i));
      if (radicand_i == '0) begin
        zero_sent++;
      end
      items_sent++;
      void'(pending_radicands.pop_front());
      drive_valid = 1'b0;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      end
    end
    if (!drive_valid && rst_ni && pending_radicands.size() != 0) begin
      if (gap_left != 0) begin
        gap_left--;
      end else begin
        drive_valid = 1'b1;
        radicand_i <= pending_radicands[0];
      end
    end
    in_valid_i <= drive_valid;
  end

  // Receiver: alternate between long stall-free stretches and stretches with
  // random stall bursts, driving ready high again between any two bursts.
  int unsigned stall_left = 0;
  int unsigned mode_left  = 0;
  logic        stall_mode = 1'b0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = ($urandom_range(0, 2) != 0);
      mode_left  = $urandom_range(200, 3000);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (stall_mode && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, MAX_STALL);
      end
    end
  end

  // Monitor: match every result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    sqrt_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (!converged_o) begin
        capped_seen++;
      end
      if (sqrt_expected.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual root %h",
                 $time, root_o);
        err_count++;
      end else begin
        want = sqrt_expected.pop_front();
        compare_field("root", want.root, root_o);
        compare_field("iterations_used", DATA_W'(want.iters), DATA_W'(iterations_used_o));
        compare_field("converged", DATA_W'(want.conv), DATA_W'(converged_o));
        compare_field("total_iterations", want.total, total_iterations_o);
        compare_field("most_iterations", DATA_W'(want.peak), DATA_W'(most_iterations_o));
      end
    end
  end

  // Watchdog: drop the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, sqrt_expected.size());
      $display("tb_newton_square_root: errors");
      $finish;
    end
  end

  // Hold until every queued radicand is accepted and every result has come back,
  // then let the block settle before anything else happens.
  task automatic drain();
    while (pending_radicands.size() != 0 || sqrt_expected.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input nsr_pkg::nsr_cfg_idx_e idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == nsr_pkg::CFG_IDX_GUESS) begin
      cur_guess = value;
    end else begin
      cur_tol = value[TOL_W-1:0];
    end
    cfg_writes++;
  endtask

  task automatic load_items(input int unsigned n_random, input bit with_corners);
    @(posedge clk_i);
    if (with_corners) begin
      foreach (corner_radicands[i]) begin
        pending_radicands.push_back(corner_radicands[i]);
      end
    end
    repeat (n_random) pending_radicands.push_back(pick_radicand());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: corners, then two random halves with a full drain
    // between them so the sender pauses until nothing is outstanding.
    load_items(0, 1'b1);
    load_items(210, 1'b0);
    load_items(210, 1'b0);

    // Smallest nonzero guess with the widest tolerance the bench writes (1.0)
    write_reg(nsr_pkg::CFG_IDX_GUESS, 32'h0000_0001);
    write_reg(nsr_pkg::CFG_IDX_TOL, 32'h0100_0000);
    load_items(60, 1'b1);

    // Largest guess with the tightest nonzero tolerance
    write_reg(nsr_pkg::CFG_IDX_GUESS, 32'hFFFF_FFFF);
    write_reg(nsr_pkg::CFG_IDX_TOL, 32'h0000_0001);
    load_items(100, 1'b1);

    // Zero guess forces a divide by zero on the first step; zero tolerance lets
    // the oscillating corner run into the iteration cap.
    write_reg(nsr_pkg::CFG_IDX_GUESS, 32'h0000_0000);
    write_reg(nsr_pkg::CFG_IDX_TOL, 32'h0000_0000);
    load_items(30, 1'b1);

    // Back to defaults, with junk above the tolerance field that must be dropped
    write_reg(nsr_pkg::CFG_IDX_TOL, 32'hFE00_0000 | 32'(nsr_pkg::TOL_RESET));
    write_reg(nsr_pkg::CFG_IDX_GUESS, nsr_pkg::GUESS_RESET);
    load_items(180, 1'b0);

    // Random settings within a sensible band
    repeat (6) begin
      write_reg(nsr_pkg::CFG_IDX_GUESS, $urandom_range(32'h0010_0000, 32'h1000_0000));
      write_reg(nsr_pkg::CFG_IDX_TOL, $urandom_range(16, 32'h0002_0000));
      load_items(100, 1'b0);
    end

    $display("summary: %0d radicands (%0d zero) over %0d register writes, %0d results checked",
             items_sent, zero_sent, cfg_writes, results_seen);
    $display("summary: %0d results hit the iteration cap, step total %0d, peak %0d",
             capped_seen, iter_total, iter_peak);
    if (err_count == 0) begin
      $display("tb_newton_square_root: clean");
    end else begin
      $display("tb_newton_square_root: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
